// ===== design/ccsv_pkg.sv =====
package ccsv_pkg;

  localparam int unsigned CUBE_W       = 32;
  localparam int unsigned CODE_W       = 2;
  localparam int unsigned VAR_IDX_W    = 5;
  localparam int unsigned CUBE_COUNT_W = 11;

  localparam logic [VAR_IDX_W-1:0] VARS_RESET = 5'd16;

  localparam logic [CODE_W-1:0] CODE_VOID = 2'd0;
  localparam logic [CODE_W-1:0] CODE_POS  = 2'd1;
  localparam logic [CODE_W-1:0] CODE_NEG  = 2'd2;
  localparam logic [CODE_W-1:0] CODE_DC   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_UPD  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  typedef struct packed {
    logic first;
    logic step;
  } scan_ctrl_t;

  typedef struct packed {
    logic                 any_binate;
    logic [VAR_IDX_W-1:0] binate_var;
    logic [VAR_IDX_W-1:0] unate_var;
  } scan_res_t;

  typedef struct packed {
    logic                    pad;
    logic [CUBE_COUNT_W-1:0] cube_count;
    logic                    has_universal_cube;
    logic [VAR_IDX_W-1:0]    most_unate_var;
    logic [VAR_IDX_W-1:0]    most_binate_var;
    logic                    any_binate;
  } out_word_t;

endpackage

// ===== design/ccsv_scan.sv =====
module ccsv_scan #(
  parameter int unsigned NUM_VARS = 16,
  parameter int unsigned CNT_W    = 11
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  ccsv_pkg::scan_ctrl_t                  ctrl_i,
  input  logic [((NUM_VARS > 1) ? $clog2(NUM_VARS) : 1)-1:0] idx_i,
  input  logic [CNT_W-1:0]                      pos_i,
  input  logic [CNT_W-1:0]                      neg_i,
  input  logic [CNT_W-1:0]                      care_i,
  output ccsv_pkg::scan_res_t                   res_o
);
  import ccsv_pkg::*;

  logic                 any_q, any_d;
  logic [VAR_IDX_W-1:0] bvar_q, bvar_d;
  logic [VAR_IDX_W-1:0] uvar_q, uvar_d;
  logic [CNT_W:0]       blits_q, blits_d;
  logic [CNT_W-1:0]     bdiff_q, bdiff_d;
  logic [CNT_W-1:0]     bcare_q, bcare_d;

  logic                 binate;
  logic [CNT_W:0]       lits;
  logic [CNT_W-1:0]     diff;
  logic [VAR_IDX_W-1:0] var_num;
  logic                 prior_any;

  always_comb begin
    binate    = (pos_i != '0) && (neg_i != '0);
    lits      = {1'b0, pos_i} + {1'b0, neg_i};
    diff      = (pos_i > neg_i) ? (pos_i - neg_i) : (neg_i - pos_i);
    var_num   = VAR_IDX_W'(idx_i) + VAR_IDX_W'(1);
    prior_any = any_q && !ctrl_i.first;

    any_d   = prior_any;
    bvar_d  = ctrl_i.first ? '0 : bvar_q;
    blits_d = blits_q;
    bdiff_d = bdiff_q;
    uvar_d  = uvar_q;
    bcare_d = bcare_q;

    if (binate) begin
      if (!prior_any || lits > blits_q || (lits == blits_q && diff < bdiff_q)) begin
        bvar_d  = var_num;
        blits_d = lits;
        bdiff_d = diff;
      end
      any_d = 1'b1;
    end
    if (ctrl_i.first || care_i > bcare_q) begin
      uvar_d  = var_num;
      bcare_d = care_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q <= 1'b0;
    end else if (ctrl_i.step) begin
      any_q <= any_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      bvar_q  <= bvar_d;
      blits_q <= blits_d;
      bdiff_q <= bdiff_d;
      uvar_q  <= uvar_d;
      bcare_q <= bcare_d;
    end
  end

  assign res_o.any_binate = any_q;
  assign res_o.binate_var = bvar_q;
  assign res_o.unate_var  = uvar_q;

  a_first_sets_unate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.step && ctrl_i.first |=> uvar_q == $past(var_num))
    else $error("first scan step did not seed the unate choice");

  a_any_needs_var: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.step && binate |=> any_q && bvar_q != '0)
    else $error("binate variable seen but no binate choice held");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_i.step |=> $stable(any_q))
    else $error("scan result moved without a step");

endmodule

// ===== design/cube_cover_splitting_variable_select.sv =====
// Splitting-variable selector. Cubes arrive one word each on the input stream, two bits per
// variable; the width register sets how many variables are in use (0 acts as 1, above
// NUM_VARS as NUM_VARS). A cube is taken in the IDLE state; the UPD state then updates all
// per-variable counters in parallel. After a cube with tlast, the SCAN state steps through the
// variables in use one at a time through a single shared compare unit that ranks binate and
// unate choices, and the FIN state posts the report, waiting while the previous report has not
// yet been taken. The report then clears all counters; the register keeps its value.
module cube_cover_splitting_variable_select #(
  parameter int unsigned NUM_VARS  = 16,
  parameter int unsigned MAX_CUBES = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [ccsv_pkg::VAR_IDX_W-1:0]        cfg_wdata_i,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // cube_codes
  input  logic [ccsv_pkg::CUBE_W-1:0]           s_axis_tdata_i,
  input  logic                                  s_axis_tlast_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // any_binate, most_binate_var, most_unate_var, has_universal_cube, cube_count
  output logic [$bits(ccsv_pkg::out_word_t)-1:0] m_axis_tdata_o
);
  import ccsv_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_CUBES + 1);
  localparam int unsigned KW    = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int unsigned NW    = $clog2(NUM_VARS + 1);

  state_e               state_q, state_d;
  logic [VAR_IDX_W-1:0] vars_q;
  logic [CUBE_W-1:0]    cube_q;
  logic                 last_q;
  logic [NW-1:0]        n_q, n_act;
  logic [KW-1:0]        k_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 univ_q;
  logic [CNT_W-1:0]     pos_q  [NUM_VARS];
  logic [CNT_W-1:0]     neg_q  [NUM_VARS];
  logic [CNT_W-1:0]     care_q [NUM_VARS];
  logic                 m_valid_q;
  out_word_t            m_data_q;

  logic [NUM_VARS-1:0]  is_pos, is_neg, is_care, is_dc;
  logic                 full, all_dc, in_acc, scan_last, fin_go;
  scan_ctrl_t           sctl;
  scan_res_t            sres;

  always_comb begin
    if (vars_q == '0) begin
      n_act = NW'(1);
    end else if (32'(vars_q) > NUM_VARS) begin
      n_act = NW'(NUM_VARS);
    end else begin
      n_act = NW'(vars_q);
    end
  end

  for (genvar k = 0; k < NUM_VARS; k++) begin : g_var
    logic [CODE_W-1:0] code;
    logic              used;
    if (2 * k + 1 < CUBE_W) begin : g_in
      assign code = cube_q[2*k+1:2*k];
    end else begin : g_void
      assign code = CODE_VOID;
    end
    assign used       = 32'(k) < 32'(n_q);
    assign is_pos[k]  = used && (code == CODE_POS);
    assign is_neg[k]  = used && (code == CODE_NEG);
    assign is_care[k] = used && (code != CODE_DC);
    assign is_dc[k]   = !used || (code == CODE_DC);
  end

  assign full      = cnt_q == CNT_W'(MAX_CUBES);
  assign all_dc    = &is_dc;
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign scan_last = (NW'(k_q) + NW'(1)) == n_q;
  assign fin_go    = (state_q == ST_FIN) && (!m_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = state_q == ST_IDLE;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_UPD;
      ST_UPD:  state_d = last_q ? ST_SCAN : ST_IDLE;
      ST_SCAN: if (scan_last) state_d = ST_FIN;
      ST_FIN:  if (fin_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vars_q  <= VARS_RESET;
      n_q     <= NW'(NUM_VARS);
      k_q     <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) vars_q <= cfg_wdata_i;
      if (in_acc) begin
        n_q    <= n_act;
        last_q <= s_axis_tlast_i;
      end
      if (state_q == ST_UPD) begin
        k_q <= '0;
      end else if (state_q == ST_SCAN && !scan_last) begin
        k_q <= k_q + KW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) cube_q <= s_axis_tdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      univ_q <= 1'b0;
      for (int k = 0; k < NUM_VARS; k++) begin
        pos_q[k]  <= '0;
        neg_q[k]  <= '0;
        care_q[k] <= '0;
      end
    end else if (fin_go) begin
      cnt_q  <= '0;
      univ_q <= 1'b0;
      for (int k = 0; k < NUM_VARS; k++) begin
        pos_q[k]  <= '0;
        neg_q[k]  <= '0;
        care_q[k] <= '0;
      end
    end else if (state_q == ST_UPD && !full) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (all_dc) univ_q <= 1'b1;
      for (int k = 0; k < NUM_VARS; k++) begin
        pos_q[k]  <= pos_q[k] + CNT_W'(is_pos[k]);
        neg_q[k]  <= neg_q[k] + CNT_W'(is_neg[k]);
        care_q[k] <= care_q[k] + CNT_W'(is_care[k]);
      end
    end
  end

  assign sctl.step  = state_q == ST_SCAN;
  assign sctl.first = k_q == '0;

  ccsv_scan #(
    .NUM_VARS (NUM_VARS),
    .CNT_W    (CNT_W)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (sctl),
    .idx_i  (k_q),
    .pos_i  (pos_q[k_q]),
    .neg_i  (neg_q[k_q]),
    .care_i (care_q[k_q]),
    .res_o  (sres)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (fin_go) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      m_data_q.pad                <= 1'b0;
      m_data_q.cube_count         <= CUBE_COUNT_W'(cnt_q);
      m_data_q.has_universal_cube <= univ_q;
      m_data_q.most_unate_var     <= sres.unate_var;
      m_data_q.most_binate_var    <= sres.binate_var;
      m_data_q.any_binate         <= sres.any_binate;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= MAX_CUBES)
    else $error("cube count past capacity");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> (32'(k_q) < 32'(n_q)) && (n_q != '0))
    else $error("scan index outside variables in use");

  a_fin_posts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> m_valid_q && cnt_q == '0 && !univ_q)
    else $error("report not posted or state not cleared");

  a_upd_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD && !full |=> cnt_q == $past(cnt_q) + CNT_W'(1))
    else $error("cube not counted");

endmodule

// ===== verif/cube_cover_splitting_variable_select_test.sv =====
`timescale 1ns / 100ps

module cube_cover_splitting_variable_select_test;
  import ccsv_pkg::*;

  localparam int unsigned NUM_VARS  = 16;
  localparam int unsigned MAX_CUBES = 1024;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic [CUBE_W-1:0] codes;
    logic              last;
  } cube_word_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [VAR_IDX_W-1:0]        cfg_wdata_i = '0;
  logic                        s_axis_tvalid_i = 1'b0;
  logic                        s_axis_tready_o;
  // cube_codes
  logic [CUBE_W-1:0]           s_axis_tdata_i = '0;
  logic                        s_axis_tlast_i = 1'b0;
  logic                        m_axis_tvalid_o;
  logic                        m_axis_tready_i = 1'b0;
  // any_binate, most_binate_var, most_unate_var, has_universal_cube, cube_count
  logic [$bits(out_word_t)-1:0] m_axis_tdata_o;

  cube_word_t  cube_q[$];
  out_word_t   report_q[$];

  int unsigned pos_cnt[NUM_VARS];
  int unsigned neg_cnt[NUM_VARS];
  int unsigned care_cnt[NUM_VARS];
  int unsigned cubes_seen = 0;
  logic        univ_seen = 1'b0;
  logic [VAR_IDX_W-1:0] width_reg = VARS_RESET;

  int unsigned err_cnt = 0;
  int unsigned cycles = 0;
  logic        in_fire = 1'b0;
  logic        tx_steady = 1'b0;
  logic        rx_steady = 1'b0;
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  cube_word_t  next_cube;
  int unsigned hold_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_mode_left = 0;
  logic [7:0]  rx_tick = '0;

  cube_cover_splitting_variable_select #(
    .NUM_VARS (NUM_VARS),
    .MAX_CUBES(MAX_CUBES)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #6 clk_i = ~clk_i;

  // Count one cube into the per-variable tallies; rank the variables on the last one.
  task automatic take_cube(input logic [CUBE_W-1:0] codes, input logic last);
    int unsigned n;
    int unsigned k;
    logic [CODE_W-1:0] c;
    logic all_dc;
    logic found;
    int unsigned lits;
    int unsigned diff;
    int unsigned best_b;
    int unsigned best_lits;
    int unsigned best_diff;
    int unsigned best_u;
    int unsigned best_care;
    out_word_t rep;
    n = (width_reg == '0) ? 1 : ((32'(width_reg) > NUM_VARS) ? NUM_VARS : 32'(width_reg));
    if (cubes_seen < MAX_CUBES) begin
      all_dc = 1'b1;
      for (k = 0; k < n; k++) begin
        c = (2 * k < CUBE_W) ? codes[2*k +: 2] : CODE_VOID;
        if (c == CODE_POS) pos_cnt[k]++;
        else if (c == CODE_NEG) neg_cnt[k]++;
        if (c != CODE_DC) begin
          care_cnt[k]++;
          all_dc = 1'b0;
        end
      end
      if (all_dc) univ_seen = 1'b1;
      cubes_seen++;
    end
    if (last) begin
      found = 1'b0;
      best_b = 0;
      best_lits = 0;
      best_diff = 0;
      best_u = 1;
      best_care = care_cnt[0];
      for (k = 0; k < n; k++) begin
        if (pos_cnt[k] > 0 && neg_cnt[k] > 0) begin
          lits = pos_cnt[k] + neg_cnt[k];
          diff = (pos_cnt[k] > neg_cnt[k]) ? pos_cnt[k] - neg_cnt[k] : neg_cnt[k] - pos_cnt[k];
          if (!found || lits > best_lits || (lits == best_lits && diff < best_diff)) begin
            best_b = k + 1;
            best_lits = lits;
            best_diff = diff;
          end
          found = 1'b1;
        end
        if (care_cnt[k] > best_care) begin
          best_u = k + 1;
          best_care = care_cnt[k];
        end
      end
      rep = '0;
      rep.any_binate = found;
      rep.most_binate_var = best_b[VAR_IDX_W-1:0];
      rep.most_unate_var = best_u[VAR_IDX_W-1:0];
      rep.has_universal_cube = univ_seen;
      rep.cube_count = cubes_seen[CUBE_COUNT_W-1:0];
      report_q.insert(report_q.size(), rep);
      for (k = 0; k < NUM_VARS; k++) begin
        pos_cnt[k] = 0;
        neg_cnt[k] = 0;
        care_cnt[k] = 0;
      end
      univ_seen = 1'b0;
      cubes_seen = 0;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    out_word_t got;
    out_word_t want;
    in_fire <= rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni) begin
      if (cfg_we_i) width_reg = cfg_wdata_i;
      if (s_axis_tvalid_i && s_axis_tready_o) take_cube(s_axis_tdata_i, s_axis_tlast_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = out_word_t'(m_axis_tdata_o);
        if (report_q.size() == 0) begin
          $display("%0t: no report expected, got %h", $time, m_axis_tdata_o);
          err_cnt++;
        end else begin
          want = report_q.pop_front();
          check_field("any_binate", 32'(want.any_binate), 32'(got.any_binate));
          check_field("most_binate_var", 32'(want.most_binate_var), 32'(got.most_binate_var));
          check_field("most_unate_var", 32'(want.most_unate_var), 32'(got.most_unate_var));
          check_field("has_universal_cube", 32'(want.has_universal_cube),
                      32'(got.has_universal_cube));
          check_field("cube_count", 32'(want.cube_count), 32'(got.cube_count));
        end
      end
    end
  end

  // Sender: bursts of words with random gaps, held while not taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid_i || in_fire)) begin
      if (cube_q.size() == 0 || (gap_left != 0 && !tx_steady)) begin
        if (gap_left != 0) gap_left--;
        s_axis_tvalid_i <= 1'b0;
      end else begin
        next_cube = cube_q.pop_front();
        s_axis_tdata_i <= next_cube.codes;
        s_axis_tlast_i <= next_cube.last;
        s_axis_tvalid_i <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 9))
            0, 1, 2, 3: gap_left = 0;
            9:          gap_left = $urandom_range(8, 30);
            default:    gap_left = $urandom_range(1, 4);
          endcase
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Receiver: stall pattern changes every so often; long hold on request.
  always @(negedge clk_i) begin
    rx_tick++;
    if (holds_done != holds_asked) begin
      hold_left = HOLD_CYCLES;
      holds_done++;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (rx_steady) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(16, 128);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        0:       m_axis_tready_i <= 1'b1;
        1:       m_axis_tready_i <= 1'($urandom_range(0, 1));
        2:       m_axis_tready_i <= ($urandom_range(0, 4) == 0);
        default: m_axis_tready_i <= rx_tick[3];
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("cube_cover_splitting_variable_select_test failed");
      $finish;
    end
  end

  task automatic push_cube(input logic [CUBE_W-1:0] codes, input logic last);
    cube_word_t w;
    w.codes = codes;
    w.last = last;
    cube_q.insert(cube_q.size(), w);
  endtask

  task automatic settle();
    while (cube_q.size() != 0 || s_axis_tvalid_i || report_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_width(input logic [VAR_IDX_W-1:0] value);
    @(negedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CUBE_W-1:0] rand_cube();
    logic [CUBE_W-1:0] v;
    int unsigned k;
    int unsigned r;
    case ($urandom_range(0, 9))
      0, 1: v = $urandom();
      2: begin
        v = '1;
        if ($urandom_range(0, 1)) begin
          v[2*$urandom_range(0, NUM_VARS-1) +: 2] = 2'($urandom_range(0, 3));
        end
      end
      default: begin
        for (k = 0; k < NUM_VARS; k++) begin
          r = $urandom_range(0, 9);
          if (r < 3) v[2*k +: 2] = CODE_POS;
          else if (r < 6) v[2*k +: 2] = CODE_NEG;
          else if (r < 9) v[2*k +: 2] = CODE_DC;
          else v[2*k +: 2] = CODE_VOID;
        end
      end
    endcase
    return v;
  endfunction

  initial begin
    int unsigned sent;
    int unsigned next_cfg;
    int unsigned len;
    int unsigned i;
    logic [CUBE_W-1:0] v;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    push_cube(32'h5555_5555, 1'b0);
    push_cube(32'hAAAA_AAAA, 1'b0);
    push_cube(32'hFFFF_FFFF, 1'b0);
    push_cube(32'h0000_0000, 1'b1);
    push_cube(32'hFFFF_FFFF, 1'b1);
    push_cube(32'h0000_0059, 1'b0);
    push_cube(32'hFFFF_FF66, 1'b0);
    push_cube(32'hFFFF_FF6A, 1'b0);
    push_cube(32'hFFFF_FF5F, 1'b0);
    push_cube(32'hFFFF_FFF7, 1'b1);
    settle();
    write_width(5'd0);
    push_cube(32'hFFFF_FFFD, 1'b0);
    push_cube(32'h0000_0003, 1'b1);
    settle();
    write_width(5'd1);
    push_cube(32'h0000_0001, 1'b0);
    push_cube(32'hFFFF_FFFE, 1'b1);
    settle();
    write_width(5'd31);
    push_cube(32'h5555_AAAA, 1'b0);
    push_cube(32'hAAAA_5555, 1'b1);
    settle();
    // change the width with a cover half loaded
    write_width(5'd4);
    push_cube(32'h1234_5679, 1'b0);
    settle();
    write_width(5'd9);
    push_cube(32'hFEDC_BA98, 1'b1);
    settle();

    // hold the output while short covers keep coming
    write_width(5'd16);
    tx_steady <= 1'b1;
    holds_asked <= holds_asked + 1;
    for (i = 0; i < 16; i++) begin
      if ($urandom_range(0, 1)) push_cube(rand_cube(), 1'b0);
      push_cube(rand_cube(), 1'b1);
    end
    settle();
    tx_steady <= 1'b0;

    sent = 0;
    next_cfg = 0;
    while (sent < 750) begin
      if (sent >= next_cfg) begin
        settle();
        case ($urandom_range(0, 9))
          0:       write_width(5'd0);
          1:       write_width(VAR_IDX_W'($urandom_range(NUM_VARS + 1, 31)));
          2:       write_width(VAR_IDX_W'(NUM_VARS));
          default: write_width(VAR_IDX_W'($urandom_range(1, NUM_VARS)));
        endcase
        next_cfg = sent + $urandom_range(60, 140);
      end
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (i = 0; i < len; i++) push_cube(rand_cube(), i == len - 1);
      sent += len;
    end
    settle();

    // fill to capacity; the cubes past it must not count
    write_width(VAR_IDX_W'(NUM_VARS));
    tx_steady <= 1'b1;
    rx_steady <= 1'b1;
    for (i = 0; i < MAX_CUBES; i++) begin
      v = rand_cube();
      v[1:0] = CODE_POS;
      push_cube(v, 1'b0);
    end
    push_cube(32'hFFFF_FFFF, 1'b0);
    push_cube(32'hFFFF_FFFF, 1'b1);
    push_cube(32'h9999_6666, 1'b1);
    settle();
    tx_steady <= 1'b0;
    rx_steady <= 1'b0;
    push_cube(rand_cube(), 1'b0);
    push_cube(rand_cube(), 1'b1);
    settle();

    if (err_cnt == 0) begin
      $display("cube_cover_splitting_variable_select_test passed");
    end else begin
      $display("cube_cover_splitting_variable_select_test failed");
    end
    $finish;
  end

endmodule
